>>> hw/rtl/thp_pkg.sv
// Shared types, constants and arithmetic helpers for the sensor compensation core.
// No dependencies; the front, queue, back and top files in hw/rtl import this package.
`timescale 1ns / 1ps
package thp_pkg;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    logic [15:0] raw_humidity;
  } thp_in_t;

  typedef struct packed {
    logic signed [15:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic [16:0]        humidity_q22_10;
    logic               pressure_divisor_zero;
  } thp_out_t;

  // Calibration words as written through the configuration port.
  typedef struct packed {
    logic [47:0] temp;
    logic [63:0] press_a;
    logic [63:0] press_b;
    logic [47:0] p9_hum;
    logic [31:0] hum_b;
  } thp_calib_t;

  // Item handed from the front (temperature, humidity) to the back (pressure).
  typedef struct packed {
    logic [31:0] t_fine;
    logic [15:0] temp_centi;
    logic [16:0] hum;
    logic [19:0] raw_pressure;
  } thp_item_t;

  typedef struct packed {
    logic       pop;
    logic [4:0] count;
  } thp_qstat_t;

  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 16;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int FE_LAT      = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP_CAL  = 3'd0,
    REG_PRESS_A   = 3'd1,
    REG_PRESS_B   = 3'd2,
    REG_P9_HUM    = 3'd3,
    REG_HUM_B     = 3'd4
  } thp_cfg_reg_e;

  localparam logic [31:0] T_OFFSET_HUM  = 32'd76800;
  localparam logic [31:0] HUM_ROUND_A   = 32'd16384;
  localparam logic [31:0] HUM_OFFSET_C  = 32'd32768;
  localparam logic [31:0] HUM_OFFSET_D  = 32'd2097152;
  localparam logic [31:0] HUM_ROUND_E   = 32'd8192;
  localparam logic [31:0] HUM_MAX       = 32'd419430400;
  localparam logic [63:0] T_OFFSET_PRS  = 64'd128000;
  localparam logic [63:0] PRS_FULL      = 64'd1048576;
  localparam logic [63:0] PRS_SCALE     = 64'd3125;
  localparam logic [63:0] PRS_BIAS      = 64'h0000_8000_0000_0000;

  function automatic logic [31:0] asr32(input logic [31:0] v, input int unsigned s);
    return $unsigned($signed(v) >>> s);
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] v, input int unsigned s);
    return $unsigned($signed(v) >>> s);
  endfunction

  function automatic logic [63:0] sx16_64(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

endpackage

>>> hw/rtl/thp_mul64.sv
// Two-stage 64x64 multiplier keeping the low 64 bits of the product.
// Depends on nothing but its ports; the partial products are registered, then their sum.
`timescale 1ns / 1ps
module thp_mul64 (
  input  logic        clk,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);
  logic [63:0] ll_r;
  logic [31:0] cross_r;
  logic [63:0] p_r;
  logic [63:0] ll_nxt;
  logic [31:0] cross_nxt;

  always_comb begin
    ll_nxt    = a[31:0] * b[31:0];
    cross_nxt = a[31:0] * b[63:32] + a[63:32] * b[31:0];
  end

  always_ff @(posedge clk) begin
    ll_r    <= ll_nxt;
    cross_r <= cross_nxt;
    p_r     <= ll_r + {cross_r, 32'd0};
  end

  assign p = p_r;
endmodule

>>> hw/rtl/thp_div.sv
// Pipelined signed 64-bit divider, truncating toward zero, one quotient bit a stage.
// Depends on nothing but its ports; accepts new operands every cycle.
`timescale 1ns / 1ps
module thp_div (
  input  logic        clk,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic [63:0] quo,
  output logic        den_zero
);
  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] q;
    logic [63:0] ud;
    logic        neg;
    logic        dz;
  } dstage_t;

  dstage_t     st_r [0:64];
  logic [64:0] sh   [0:63];
  logic [64:0] diff [0:63];
  logic        ge   [0:63];
  logic [63:0] quo_r;
  logic        dz_r;

  always_comb begin
    for (int i = 0; i < 64; i++) begin
      sh[i]   = {st_r[i].rem, st_r[i].q[63]};
      diff[i] = sh[i] - {1'b0, st_r[i].ud};
      ge[i]   = (sh[i] >= {1'b0, st_r[i].ud});
    end
  end

  always_ff @(posedge clk) begin
    st_r[0].rem <= '0;
    st_r[0].q   <= num[63] ? (64'd0 - num) : num;
    st_r[0].ud  <= den[63] ? (64'd0 - den) : den;
    st_r[0].neg <= num[63] ^ den[63];
    st_r[0].dz  <= (den == 64'd0);
    for (int i = 0; i < 64; i++) begin
      st_r[i+1].rem <= ge[i] ? diff[i][63:0] : sh[i][63:0];
      st_r[i+1].q   <= {st_r[i].q[62:0], ge[i]};
      st_r[i+1].ud  <= st_r[i].ud;
      st_r[i+1].neg <= st_r[i].neg;
      st_r[i+1].dz  <= st_r[i].dz;
    end
    quo_r <= st_r[64].neg ? (64'd0 - st_r[64].q) : st_r[64].q;
    dz_r  <= st_r[64].dz;
  end

  assign quo      = quo_r;
  assign den_zero = dz_r;
endmodule

>>> hw/rtl/thp_front.sv
// Front pipeline: temperature and fine-temperature term, then humidity (32-bit math).
// Uses thp_pkg; ten stages, one item per cycle.
`timescale 1ns / 1ps
module thp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_take,
  input  thp_pkg::thp_in_t    in_data,
  input  thp_pkg::thp_calib_t calib,
  output logic                item_valid,
  output thp_pkg::thp_item_t  item
);
  import thp_pkg::*;

  logic [FE_LAT-1:0] vld_r;
  logic [19:0] adcp_r [0:FE_LAT-1];
  logic [15:0] adch_r [0:2];
  logic [31:0] pa1_r, pb1_r, v1_r, bt3_r, tf3_r;
  logic [31:0] tfd_r  [0:6];
  logic [15:0] toutd_r [0:6];
  logic [31:0] base4_r, m1_r, m2_r, m3_r;
  logic [31:0] ha5_r, prod5_r, ha6_r, md6_r, xx7_r, xx8_r, ss8_r, xx9_r, t9_r;
  logic [16:0] hum_r;

  logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
  logic [31:0] a, b, tc, xh, ha, hb, hc, hd, he, sv, xf;
  logic [15:0] tout;
  logic [16:0] hum_nxt;

  always_comb begin
    t1 = {16'd0, calib.temp[15:0]};
    t2 = {{16{calib.temp[31]}}, calib.temp[31:16]};
    t3 = {{16{calib.temp[47]}}, calib.temp[47:32]};
    h1 = {24'd0, calib.p9_hum[23:16]};
    h2 = {{16{calib.p9_hum[39]}}, calib.p9_hum[39:24]};
    h3 = {24'd0, calib.p9_hum[47:40]};
    h4 = {{20{calib.hum_b[11]}}, calib.hum_b[11:0]};
    h5 = {{20{calib.hum_b[23]}}, calib.hum_b[23:12]};
    h6 = {{24{calib.hum_b[31]}}, calib.hum_b[31:24]};
    a  = {15'd0, in_data.raw_temperature[19:3]} - {15'd0, t1[15:0], 1'b0};
    b  = {16'd0, in_data.raw_temperature[19:4]} - t1;
    // centi-degrees, saturated to 16 bits
    tc = asr32(tf3_r * 32'd5 + 32'd128, 8);
    if (tc[31] && tc < 32'hFFFF_8000) tout = 16'h8000;
    else if (!tc[31] && tc > 32'h0000_7FFF) tout = 16'h7FFF;
    else tout = tc[15:0];
    xh = tf3_r - T_OFFSET_HUM;
    ha = asr32(base4_r - m1_r, 15);
    hb = asr32(m2_r, 10);
    hc = asr32(m3_r, 11) + HUM_OFFSET_C;
    hd = asr32(prod5_r, 10) + HUM_OFFSET_D;
    he = asr32(md6_r + HUM_ROUND_E, 14);
    sv = asr32(xx7_r, 15);
    xf = xx9_r - asr32(t9_r, 4);
    if (xf[31]) hum_nxt = '0;
    else if (xf > HUM_MAX) hum_nxt = HUM_MAX[28:12];
    else hum_nxt = xf[28:12];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[FE_LAT-2:0], in_take};
    end
  end

  always_ff @(posedge clk) begin
    adcp_r[0] <= in_data.raw_pressure;
    adch_r[0] <= in_data.raw_humidity;
    for (int i = 1; i < FE_LAT; i++) adcp_r[i] <= adcp_r[i-1];
    for (int i = 1; i < 3; i++) adch_r[i] <= adch_r[i-1];
    // temperature
    pa1_r   <= a * t2;
    pb1_r   <= b * b;
    v1_r    <= asr32(pa1_r, 11);
    bt3_r   <= asr32(pb1_r, 12) * t3;
    tf3_r   <= v1_r + asr32(bt3_r, 14);
    // humidity
    tfd_r[0]   <= tf3_r;
    toutd_r[0] <= tout;
    for (int i = 1; i < 7; i++) begin
      tfd_r[i]   <= tfd_r[i-1];
      toutd_r[i] <= toutd_r[i-1];
    end
    base4_r <= {2'd0, adch_r[2], 14'd0} - {h4[11:0], 20'd0} + HUM_ROUND_A;
    m1_r    <= h5 * xh;
    m2_r    <= xh * h6;
    m3_r    <= xh * h3;
    ha5_r   <= ha;
    prod5_r <= hb * hc;
    ha6_r   <= ha5_r;
    md6_r   <= hd * h2;
    xx7_r   <= ha6_r * he;
    xx8_r   <= xx7_r;
    ss8_r   <= sv * sv;
    xx9_r   <= xx8_r;
    t9_r    <= asr32(ss8_r, 7) * h1;
    hum_r   <= hum_nxt;
  end

  assign item_valid        = vld_r[FE_LAT-1];
  assign item.t_fine       = tfd_r[6];
  assign item.temp_centi   = toutd_r[6];
  assign item.hum          = hum_r;
  assign item.raw_pressure = adcp_r[FE_LAT-1];
endmodule

>>> hw/rtl/thp_queue.sv
// Short FIFO between front and back; the back drains it whenever it holds an item.
// Uses thp_pkg for the item type and depth. Read data is registered: stat.pop marks it.
`timescale 1ns / 1ps
module thp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  thp_pkg::thp_item_t  push_item,
  output thp_pkg::thp_qstat_t stat,
  output thp_pkg::thp_item_t  pop_item
);
  import thp_pkg::*;

  thp_item_t           mem_r [0:QUEUE_DEPTH-1];
  thp_item_t           rd_r;
  logic [QUEUE_AW-1:0] wp_r, rp_r;
  logic [QUEUE_AW:0]   cnt_r, cnt_nxt;
  logic                pop;
  logic                pop_r;

  always_comb begin
    pop     = (cnt_r != '0);
    cnt_nxt = cnt_r + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
      pop_r <= 1'b0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
      pop_r <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_item;
    if (pop) rd_r <= mem_r[rp_r];
  end

  assign pop_item   = rd_r;
  assign stat.pop   = pop_r;
  assign stat.count = 5'(cnt_r);
endmodule

>>> hw/rtl/thp_back.sv
// Back pipeline: 64-bit pressure compensation with the pipelined divider.
// Uses thp_pkg, thp_mul64 and thp_div.
`timescale 1ns / 1ps
module thp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pop,
  input  thp_pkg::thp_item_t  pop_item,
  input  thp_pkg::thp_calib_t calib,
  output logic                out_valid,
  output thp_pkg::thp_out_t   out_data
);
  import thp_pkg::*;

  localparam int BK_LAT = 81;

  logic [BK_LAT-1:0] vld_r;
  logic [15:0] tout_r [1:BK_LAT-1];
  logic [16:0] hum_r  [1:BK_LAT-1];
  logic [63:0] d0_r   [1:6];
  logic [63:0] m5d_r  [4:5];
  logic [63:0] m2d_r  [4:5];
  logic [63:0] qd_r   [76:79];
  logic [63:0] m8d_r  [78:79];
  logic        dzd_r  [76:80];
  logic [63:0] q1_r, q2_r, q1b_r, v_r, dn_r, sum_r;
  thp_out_t    out_r;

  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [63:0] sq, m5, m2, a6, a3, vp, num, quo, ps, pss, m8, m9, pr;
  logic        dz;

  always_comb begin
    p1 = {48'd0, calib.press_a[15:0]};
    p2 = sx16_64(calib.press_a[31:16]);
    p3 = sx16_64(calib.press_a[47:32]);
    p4 = sx16_64(calib.press_a[63:48]);
    p5 = sx16_64(calib.press_b[15:0]);
    p6 = sx16_64(calib.press_b[31:16]);
    p7 = sx16_64(calib.press_b[47:32]);
    p8 = sx16_64(calib.press_b[63:48]);
    p9 = sx16_64(calib.p9_hum[15:0]);
    ps = asr64(quo, 13);
    pr = asr64(sum_r, 8) + {p7[59:0], 4'd0};
  end

  thp_mul64 u_mul_sq (.clk, .a(q1_r), .b(q1_r), .p(sq));
  thp_mul64 u_mul_m5 (.clk, .a(q1_r), .b(p5),   .p(m5));
  thp_mul64 u_mul_m2 (.clk, .a(q1_r), .b(p2),   .p(m2));
  thp_mul64 u_mul_a6 (.clk, .a(sq),   .b(p6),   .p(a6));
  thp_mul64 u_mul_a3 (.clk, .a(sq),   .b(p3),   .p(a3));
  thp_mul64 u_mul_vp (.clk, .a(v_r),  .b(p1),   .p(vp));
  thp_mul64 u_mul_nm (.clk, .a(dn_r), .b(PRS_SCALE), .p(num));

  thp_div u_div (.clk, .num(num), .den(asr64(vp, 33)), .quo(quo), .den_zero(dz));

  thp_mul64 u_mul_ps (.clk, .a(ps),  .b(ps),  .p(pss));
  thp_mul64 u_mul_m8 (.clk, .a(p8),  .b(quo), .p(m8));
  thp_mul64 u_mul_m9 (.clk, .a(p9),  .b(pss), .p(m9));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[BK_LAT-2:0], pop};
    end
  end

  always_ff @(posedge clk) begin
    tout_r[1] <= pop_item.temp_centi;
    hum_r[1]  <= pop_item.hum;
    for (int i = 2; i < BK_LAT; i++) begin
      tout_r[i] <= tout_r[i-1];
      hum_r[i]  <= hum_r[i-1];
    end
    q1_r     <= {{32{pop_item.t_fine[31]}}, pop_item.t_fine} - T_OFFSET_PRS;
    d0_r[1]  <= PRS_FULL - {44'd0, pop_item.raw_pressure};
    for (int i = 2; i <= 6; i++) d0_r[i] <= d0_r[i-1];
    m5d_r[4] <= m5;
    m5d_r[5] <= m5d_r[4];
    m2d_r[4] <= m2;
    m2d_r[5] <= m2d_r[4];
    q2_r     <= a6 + {m5d_r[5][46:0], 17'd0} + {p4[28:0], 35'd0};
    q1b_r    <= asr64(a3, 8) + {m2d_r[5][51:0], 12'd0};
    v_r      <= PRS_BIAS + q1b_r;
    dn_r     <= {d0_r[6][32:0], 31'd0} - q2_r;
    qd_r[76] <= quo;
    for (int i = 77; i <= 79; i++) qd_r[i] <= qd_r[i-1];
    m8d_r[78] <= m8;
    m8d_r[79] <= m8d_r[78];
    dzd_r[76] <= dz;
    for (int i = 77; i <= 80; i++) dzd_r[i] <= dzd_r[i-1];
    sum_r    <= qd_r[79] + asr64(m9, 25) + asr64(m8d_r[79], 19);
    // saturate to Q24.8 (a negative result gives zero), force zero when the divisor was zero
    out_r.temperature_centi     <= tout_r[BK_LAT-1];
    out_r.humidity_q22_10       <= hum_r[BK_LAT-1];
    out_r.pressure_divisor_zero <= dzd_r[80];
    if (dzd_r[80] || pr[63]) out_r.pressure_q24_8 <= '0;
    else if (pr[63:32] != '0) out_r.pressure_q24_8 <= '1;
    else out_r.pressure_q24_8 <= pr[31:0];
  end

  assign out_valid = vld_r[BK_LAT-1];
  assign out_data  = out_r;
endmodule

>>> hw/rtl/thp_sensor_compensation_core.sv
// Top level of the sensor compensation core: configuration registers and the
// front, queue and back pipelines. Uses thp_pkg and all other files in hw/rtl.
`timescale 1ns / 1ps
// Usage
//   Input: drive in_data and raise start; the sample is taken at an edge with
//   start high and busy low. A new sample may be given every cycle.
//   Output: out_valid strobes for one cycle with out_data; the receiver
//   cannot stall, so the result is gone after that cycle.
//   Configuration: cfg_valid/cfg_ready write channel, cfg_index selects the
//   calibration word (0 temperature, 1 and 2 pressure, 3 P9 and humidity,
//   4 humidity), cfg_wdata carries it; an index past the list is dropped.
//   Write calibration only while no sample is in flight.
// Path and throughput
//   An accepted sample passes the temperature and humidity front, the
//   queue (write, then a registered read) and the pressure back, which
//   holds the bit-per-stage divider. Throughput is one transaction per
//   cycle; busy rises only once the queue holds QUEUE_DEPTH - FE_LAT
//   items, which a back that never stalls does not let happen.
// Reset
//   rst_n (synchronous, active low) clears the calibration words to zero,
//   empties the queue and drops every transaction in flight.
module thp_sensor_compensation_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  thp_pkg::thp_in_t                 in_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [thp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [63:0]                      cfg_wdata,
  output logic                             out_valid,
  output thp_pkg::thp_out_t                out_data
);
  import thp_pkg::*;

  thp_calib_t calib_r;
  thp_item_t  fe_item, q_item;
  thp_qstat_t qstat;
  logic       fe_valid;
  logic       in_take;

  // Hold busy once the queue could not absorb everything in the front.
  assign busy      = (qstat.count >= 5'(QUEUE_DEPTH - FE_LAT));
  assign in_take   = start & ~busy;
  assign cfg_ready = 1'b1;

  // Calibration words; drop writes to unknown indexes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (thp_cfg_reg_e'(cfg_index))
        REG_TEMP_CAL: calib_r.temp    <= cfg_wdata[47:0];
        REG_PRESS_A:  calib_r.press_a <= cfg_wdata;
        REG_PRESS_B:  calib_r.press_b <= cfg_wdata;
        REG_P9_HUM:   calib_r.p9_hum  <= cfg_wdata[47:0];
        REG_HUM_B:    calib_r.hum_b   <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  thp_front u_front (
    .clk, .rst_n, .in_take, .in_data, .calib(calib_r),
    .item_valid(fe_valid), .item(fe_item)
  );

  thp_queue u_queue (
    .clk, .rst_n, .push(fe_valid), .push_item(fe_item),
    .stat(qstat), .pop_item(q_item)
  );

  thp_back u_back (
    .clk, .rst_n, .pop(qstat.pop), .pop_item(q_item), .calib(calib_r),
    .out_valid, .out_data
  );
endmodule

>>> sim/testbench.sv
// Self-checking testbench for thp_sensor_compensation_core: predicts each compensated sample
// in SystemVerilog and compares it with every result strobe. Depends on thp_pkg and the core.
`timescale 1ns / 1ps
module testbench;
  import thp_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  thp_in_t           in_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0]       cfg_wdata;
  logic              out_valid;
  thp_out_t          out_data;

  // Calibration shadow used by the predictor.
  logic [47:0] cal_temp;
  logic [63:0] cal_press_a;
  logic [63:0] cal_press_b;
  logic [47:0] cal_p9_hum;
  logic [31:0] cal_hum_b;

  thp_in_t  sample_q[$];
  thp_out_t compensated_q[$];
  bit       failed;
  int       burst_left;
  int       gap_left;
  int       mismatch_count;

  thp_sensor_compensation_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .out_valid(out_valid), .out_data(out_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [31:0] sra32(logic [31:0] v, int s);
    return $unsigned($signed(v) >>> s);
  endfunction

  function automatic logic [63:0] sra64(logic [63:0] v, int s);
    return $unsigned($signed(v) >>> s);
  endfunction

  function automatic logic [31:0] sext(logic [31:0] v, int w);
    logic [31:0] m;
    m = 32'd1 << (w - 1);
    v = v & ((m << 1) - 32'd1);
    return (v ^ m) - m;
  endfunction

  // Compensate one raw sample with the current calibration shadow.
  function automatic thp_out_t compensate(thp_in_t s);
    thp_out_t r;
    logic [31:0] t1, t2, t3, h1, h2, h3, h4, h5, h6;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] a, b, v1, v2, tf, tc, x, ha, hb, hc, hd, he, sh;
    logic [63:0] q1, q2, p, un, ud, qt;
    logic [31:0] adc_t, adc_h;
    t1 = {16'd0, cal_temp[15:0]};
    t2 = sext(cal_temp[31:16], 16);
    t3 = sext(cal_temp[47:32], 16);
    p1 = {48'd0, cal_press_a[15:0]};
    p2 = {{48{cal_press_a[31]}}, cal_press_a[31:16]};
    p3 = {{48{cal_press_a[47]}}, cal_press_a[47:32]};
    p4 = {{48{cal_press_a[63]}}, cal_press_a[63:48]};
    p5 = {{48{cal_press_b[15]}}, cal_press_b[15:0]};
    p6 = {{48{cal_press_b[31]}}, cal_press_b[31:16]};
    p7 = {{48{cal_press_b[47]}}, cal_press_b[47:32]};
    p8 = {{48{cal_press_b[63]}}, cal_press_b[63:48]};
    p9 = {{48{cal_p9_hum[15]}}, cal_p9_hum[15:0]};
    h1 = {24'd0, cal_p9_hum[23:16]};
    h2 = sext(cal_p9_hum[39:24], 16);
    h3 = {24'd0, cal_p9_hum[47:40]};
    h4 = sext(cal_hum_b[11:0], 12);
    h5 = sext(cal_hum_b[23:12], 12);
    h6 = sext(cal_hum_b[31:24], 8);
    adc_t = {12'd0, s.raw_temperature};
    adc_h = {16'd0, s.raw_humidity};

    // Temperature and fine-temperature term.
    a  = (adc_t >> 3) - (t1 << 1);
    v1 = sra32(a * t2, 11);
    b  = (adc_t >> 4) - t1;
    v2 = sra32(sra32(b * b, 12) * t3, 14);
    tf = v1 + v2;
    tc = sra32(tf * 32'd5 + 32'd128, 8);
    if ($signed(tc) < -32768) r.temperature_centi = 16'sh8000;
    else if ($signed(tc) > 32767) r.temperature_centi = 16'sh7FFF;
    else r.temperature_centi = tc[15:0];

    // Pressure, 64-bit with one signed division.
    q1 = {{32{tf[31]}}, tf} - 64'd128000;
    q2 = q1 * q1 * p6;
    q2 = q2 + ((q1 * p5) << 17);
    q2 = q2 + (p4 << 35);
    q1 = sra64(q1 * q1 * p3, 8) + ((q1 * p2) << 12);
    q1 = sra64(((64'd1 << 47) + q1) * p1, 33);
    if (q1 == 64'd0) begin
      r.pressure_q24_8 = 32'd0;
      r.pressure_divisor_zero = 1'b1;
    end else begin
      r.pressure_divisor_zero = 1'b0;
      p  = 64'd1048576 - {44'd0, s.raw_pressure};
      p  = ((p << 31) - q2) * 64'd3125;
      un = p[63] ? -p : p;
      ud = q1[63] ? -q1 : q1;
      qt = un / ud;
      p  = (p[63] != q1[63]) ? -qt : qt;
      q1 = sra64(p9 * sra64(p, 13) * sra64(p, 13), 25);
      q2 = sra64(p8 * p, 19);
      p  = sra64(p + q1 + q2, 8) + (p7 << 4);
      if (p[63]) r.pressure_q24_8 = 32'd0;
      else if (p > 64'hFFFF_FFFF) r.pressure_q24_8 = 32'hFFFF_FFFF;
      else r.pressure_q24_8 = p[31:0];
    end

    // Humidity, 32-bit then clamped.
    x  = tf - 32'd76800;
    ha = sra32((adc_h << 14) - (h4 << 20) - h5 * x + 32'd16384, 15);
    hb = sra32(x * h6, 10);
    hc = sra32(x * h3, 11) + 32'd32768;
    hd = sra32(hb * hc, 10) + 32'd2097152;
    he = sra32(hd * h2 + 32'd8192, 14);
    x  = ha * he;
    sh = sra32(x, 15);
    x  = x - sra32(sra32(sh * sh, 7) * h1, 4);
    if (x[31]) x = 32'd0;
    else if (x > 32'd419430400) x = 32'd419430400;
    r.humidity_q22_10 = x[28:12];
    return r;
  endfunction

  // Driver: hold start while a transaction is pending, in bursts with gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        compensated_q.push_back(compensate(in_data));
        void'(sample_q.pop_front());
      end
      if (sample_q.size() > ((start && !busy) ? 0 : 0) &&
          !(start && !busy && sample_q.size() == 0)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else begin
          start <= 1'b1;
          in_data <= sample_q[0];
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(40, 0);
            gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
          end
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check every result strobe against the oldest prediction.
  always @(posedge clk) begin
    thp_out_t want;
    if (rst_n && out_valid) begin
      if (compensated_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        failed = 1'b1;
      end else begin
        want = compensated_q.pop_front();
        if (want.temperature_centi !== out_data.temperature_centi ||
            want.pressure_q24_8 !== out_data.pressure_q24_8 ||
            want.humidity_q22_10 !== out_data.humidity_q22_10 ||
            want.pressure_divisor_zero !== out_data.pressure_divisor_zero) begin
          failed = 1'b1;
          if (mismatch_count < 40)
            $display("%0t: mismatch expected %h actual %h", $time, want, out_data);
          mismatch_count++;
        end
      end
    end
  end

  task automatic cfg_write(thp_cfg_reg_e idx, logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_TEMP_CAL: cal_temp    = val[47:0];
      REG_PRESS_A:  cal_press_a = val;
      REG_PRESS_B:  cal_press_b = val;
      REG_P9_HUM:   cal_p9_hum  = val[47:0];
      REG_HUM_B:    cal_hum_b   = val[31:0];
      default: ;
    endcase
  endtask

  // Drop an out-of-list index; the shadow must not change.
  task automatic cfg_write_stray(logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IDX_W'(5 + $urandom_range(2, 0));
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (sample_q.size() != 0 || start || compensated_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Typical device calibration, with small random spread.
  task automatic load_typical();
    cfg_write(REG_TEMP_CAL, {16'd50, 16'd26435 + 16'($urandom_range(200, 0)),
                             16'd27504 + 16'($urandom_range(500, 0))});
    cfg_write(REG_PRESS_A, {16'd2855, 16'hF3FE, 16'hD6D0, 16'd36477});
    cfg_write(REG_PRESS_B, {16'hC0E0, 16'd15500, 16'hFFF9, 16'd140});
    cfg_write(REG_P9_HUM, {8'd0, 16'd362, 8'd75, 16'd6000});
    cfg_write(REG_HUM_B, {8'd30, 12'd50, 12'd313});
  endtask

  task automatic push_random(int n);
    thp_in_t s;
    repeat (n) begin
      s.raw_temperature = ($urandom_range(3, 0) == 0) ? 20'($urandom) :
                          20'($urandom_range(560000, 480000));
      s.raw_pressure = ($urandom_range(3, 0) == 0) ? 20'($urandom) :
                       20'($urandom_range(420000, 250000));
      s.raw_humidity = ($urandom_range(3, 0) == 0) ? 16'($urandom) :
                       16'($urandom_range(32000, 20000));
      sample_q.push_back(s);
    end
  endtask

  initial begin
    thp_in_t s;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    failed = 1'b0;
    mismatch_count = 0;
    cal_temp = '0; cal_press_a = '0; cal_press_b = '0; cal_p9_hum = '0; cal_hum_b = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset calibration: divisor is zero everywhere.
    s = '0; sample_q.push_back(s);
    s = '1; sample_q.push_back(s);
    drain();

    // Directed: field extremes under typical calibration.
    load_typical();
    cfg_write_stray(rand64());
    s = '{20'd0, 20'd0, 16'd0};           sample_q.push_back(s);
    s = '{20'hFFFFF, 20'hFFFFF, 16'hFFFF}; sample_q.push_back(s);
    s = '{20'd519888, 20'd415148, 16'd27000}; sample_q.push_back(s);
    s = '{20'hFFFFF, 20'd0, 16'd0};       sample_q.push_back(s);
    s = '{20'd0, 20'hFFFFF, 16'hFFFF};    sample_q.push_back(s);
    s = '{20'd300000, 20'd300000, 16'd60000}; sample_q.push_back(s);
    s = '{20'd700000, 20'd100000, 16'd1000};  sample_q.push_back(s);
    drain();

    // Directed: all-ones calibration, then extreme signed values.
    cfg_write(REG_TEMP_CAL, '1);
    cfg_write(REG_PRESS_A, '1);
    cfg_write(REG_PRESS_B, '1);
    cfg_write(REG_P9_HUM, '1);
    cfg_write(REG_HUM_B, '1);
    s = '0; sample_q.push_back(s);
    s = '1; sample_q.push_back(s);
    push_random(4);
    drain();
    cfg_write(REG_TEMP_CAL, {16'h8000, 16'h7FFF, 16'hFFFF});
    cfg_write(REG_PRESS_A, {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF});
    cfg_write(REG_PRESS_B, {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
    cfg_write(REG_P9_HUM, {8'hFF, 16'h8000, 8'hFF, 16'h7FFF});
    cfg_write(REG_HUM_B, {8'h80, 12'h7FF, 12'h800});
    s = '0; sample_q.push_back(s);
    s = '1; sample_q.push_back(s);
    push_random(4);
    drain();

    // Random phases: mostly realistic calibration, some fully random words.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph % 3 == 2) begin
        cfg_write(REG_TEMP_CAL, rand64());
        cfg_write(REG_PRESS_A, rand64());
        cfg_write(REG_PRESS_B, rand64());
        cfg_write(REG_P9_HUM, rand64());
        cfg_write(REG_HUM_B, rand64());
      end else begin
        load_typical();
      end
      push_random(110);
      drain();
    end

    if (!failed && compensated_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
